[rtl/rtp_pkg.sv]
// Package: shared constants, types and helpers for the radix integer text parser.
`timescale 1ns / 1ps

package rtp_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned PROD_W  = VALUE_W + RADIX_W;

  localparam logic [COUNT_W-1:0] MAX_COUNT = 16'hFFFF;

  // Parse phases
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_NUMSTART = 3'd1;
  localparam logic [2:0] PH_ZERO     = 3'd2;
  localparam logic [2:0] PH_DIGITS   = 3'd3;
  localparam logic [2:0] PH_STOPPED  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_RADIX  = 1'b0;
  localparam logic CFG_SIGNED = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [RADIX_W-1:0] RADIX_2  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_8  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_10 = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_16 = 6'd16;

  typedef struct packed {
    logic               ok;
    logic [RADIX_W-1:0] value;
  } digit_t;

  // Alphanumeric digit decode: 0-9, a-z, A-Z give 0..35.
  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t r;
    logic [7:0] t;
    r.ok    = 1'b1;
    r.value = '0;
    t       = '0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + 8'd10;
    end else begin
      r.ok = 1'b0;
    end
    r.value = t[RADIX_W-1:0];
    return r;
  endfunction

  // Saturating count add
  function automatic logic [COUNT_W-1:0] count_add(input logic [COUNT_W-1:0] c,
                                                   input logic [1:0] n);
    logic [COUNT_W:0] s;
    s = {1'b0, c} + {{(COUNT_W - 1){1'b0}}, n};
    return (s > {1'b0, MAX_COUNT}) ? MAX_COUNT : s[COUNT_W-1:0];
  endfunction

endpackage

[rtl/radix_integer_text_parser_top.sv]
// Top level: streaming integer parser with radix prefix sensing, one byte per transfer.
`timescale 1ns / 1ps

// Channel   | Direction | Signals                     | Contents (lowest bit first)
// s_*       | in        | s_tvalid/s_tready/s_tdata   | tdata: char_byte[7:0]
//           |           | s_tuser, s_tlast            | tuser: char_valid; tlast: last_char
// m_*       | out       | m_tvalid/m_tready/m_tdata   | tdata: value_bits[63:0], parse_error,
//           |           |                             |   consumed_count[15:0], radix_used[5:0], pad
// cfg_*     | in        | cfg_we/cfg_index/cfg_data   | 0: radix_select[5:0], 1: signed_mode
//
// Cycles: one byte per cycle while s_tready is high. Each byte is folded into the
// accumulator by a single 64x6 multiply-add in the cycle it is taken.
// A result goes from the last byte into the pending stage (sign and range
// check), then into the output register once that register is free.
// Reset (rst, synchronous) clears the parse state, the registers and both stages.
// Stalls: input waits only while the pending stage is full and the output is held.

module radix_integer_text_parser_top (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // char_byte[7:0]
  input  logic                        s_tuser,   // char_valid
  input  logic                        s_tlast,   // last_char
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [87:0]                 m_tdata,   // value_bits[63:0], parse_error[64],
                                                 // consumed_count[80:65], radix_used[86:81]
  // configuration
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rtp_pkg::RADIX_W-1:0] cfg_data
);

  // configuration registers
  logic [rtp_pkg::RADIX_W-1:0] radix_select;
  logic                        signed_mode;

  // parse state
  logic [2:0]                  phase, phase_next;
  logic [rtp_pkg::VALUE_W-1:0] acc, acc_next;
  logic [rtp_pkg::RADIX_W-1:0] radix, radix_next;
  logic                        neg, neg_next;
  logic                        seen, seen_next;
  logic                        ovf, ovf_next;
  logic [rtp_pkg::COUNT_W-1:0] cnt, cnt_next;

  // finalize values for the last byte
  logic [rtp_pkg::RADIX_W-1:0] fin_radix;
  logic                        fin_seen;
  logic [rtp_pkg::COUNT_W-1:0] fin_cnt;

  // pending stage
  logic                        pend_valid;
  logic [rtp_pkg::VALUE_W-1:0] pend_acc;
  logic                        pend_ovf;
  logic                        pend_seen;
  logic                        pend_neg;
  logic                        pend_sm;
  logic [rtp_pkg::COUNT_W-1:0] pend_cnt;
  logic [rtp_pkg::RADIX_W-1:0] pend_radix;

  // output register
  logic                        out_valid;
  logic [rtp_pkg::VALUE_W-1:0] out_value;
  logic                        out_err;
  logic [rtp_pkg::COUNT_W-1:0] out_cnt;
  logic [rtp_pkg::RADIX_W-1:0] out_radix;

  logic                        in_xfer;
  logic                        out_free;
  logic                        out_load;

  assign out_free = !out_valid || m_tready;
  assign out_load = pend_valid && out_free;
  assign s_tready = !pend_valid || out_free;
  assign in_xfer  = s_tvalid && s_tready;

  // digit step datapath
  logic                        dig_try;
  logic [7:0]                  dig_char;
  rtp_pkg::digit_t             dig;
  logic [rtp_pkg::PROD_W-1:0]  prod;
  logic [1:0]                  cnt_inc;

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    radix_next = radix;
    neg_next   = neg;
    seen_next  = seen;
    ovf_next   = ovf;
    cnt_inc    = 2'd0;
    dig_try    = 1'b0;
    dig_char   = s_tdata;

    if (s_tuser) begin
      unique case (phase) inside
        rtp_pkg::PH_START, rtp_pkg::PH_NUMSTART: begin
          if (phase == rtp_pkg::PH_START && signed_mode && s_tdata == rtp_pkg::CH_MINUS) begin
            neg_next   = 1'b1;
            cnt_inc    = 2'd1;
            phase_next = rtp_pkg::PH_NUMSTART;
          end else if (radix_select == '0 && s_tdata == rtp_pkg::CH_0) begin
            phase_next = rtp_pkg::PH_ZERO;
          end else begin
            radix_next = (radix_select == '0) ? rtp_pkg::RADIX_10 : radix_select;
            phase_next = rtp_pkg::PH_DIGITS;
            dig_try    = 1'b1;
          end
        end
        rtp_pkg::PH_ZERO: begin
          phase_next = rtp_pkg::PH_DIGITS;
          if (s_tdata == rtp_pkg::CH_LX || s_tdata == rtp_pkg::CH_UX) begin
            radix_next = rtp_pkg::RADIX_16;
            cnt_inc    = 2'd2;
          end else if (s_tdata == rtp_pkg::CH_LB || s_tdata == rtp_pkg::CH_UB) begin
            radix_next = rtp_pkg::RADIX_2;
            cnt_inc    = 2'd2;
          end else if (s_tdata == rtp_pkg::CH_LO) begin
            radix_next = rtp_pkg::RADIX_8;
            cnt_inc    = 2'd2;
          end else if (s_tdata >= rtp_pkg::CH_0 && s_tdata <= rtp_pkg::CH_9) begin
            // leading zero of an octal literal; the digit follows below
            radix_next = rtp_pkg::RADIX_8;
            cnt_inc    = 2'd1;
            dig_try    = 1'b1;
          end else begin
            // lone zero then a non-digit: the zero is the number
            radix_next = rtp_pkg::RADIX_10;
            seen_next  = 1'b1;
            cnt_inc    = 2'd1;
            phase_next = rtp_pkg::PH_STOPPED;
          end
        end
        rtp_pkg::PH_DIGITS: begin
          dig_try = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // shared multiply-add; exact overflow shows in the top product bits
    dig  = rtp_pkg::digit_of(dig_char);
    prod = rtp_pkg::PROD_W'(acc) * rtp_pkg::PROD_W'(radix_next)
         + rtp_pkg::PROD_W'(dig.value);
    if (dig_try) begin
      if (!dig.ok || dig.value >= radix_next) begin
        phase_next = rtp_pkg::PH_STOPPED;
      end else if (prod[rtp_pkg::PROD_W-1:rtp_pkg::VALUE_W] != '0) begin
        ovf_next   = 1'b1;
        phase_next = rtp_pkg::PH_STOPPED;
      end else begin
        acc_next  = prod[rtp_pkg::VALUE_W-1:0];
        seen_next = 1'b1;
        cnt_inc   = cnt_inc + 2'd1;
      end
    end
    cnt_next = rtp_pkg::count_add(cnt, cnt_inc);

    // end of string: settle a radix that was never chosen, a pending zero
    fin_radix = radix_next;
    fin_seen  = seen_next;
    fin_cnt   = cnt_next;
    if (phase_next == rtp_pkg::PH_START || phase_next == rtp_pkg::PH_NUMSTART) begin
      fin_radix = (radix_select == '0) ? rtp_pkg::RADIX_10 : radix_select;
    end else if (phase_next == rtp_pkg::PH_ZERO) begin
      fin_radix = rtp_pkg::RADIX_10;
      fin_seen  = 1'b1;
      fin_cnt   = rtp_pkg::count_add(cnt_next, 2'd1);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_select <= '0;
      signed_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtp_pkg::CFG_RADIX:  radix_select <= cfg_data;
        rtp_pkg::CFG_SIGNED: signed_mode  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst || (in_xfer && s_tlast)) begin
      phase <= rtp_pkg::PH_START;
      acc   <= '0;
      radix <= '0;
      neg   <= 1'b0;
      seen  <= 1'b0;
      ovf   <= 1'b0;
      cnt   <= '0;
    end else if (in_xfer) begin
      phase <= phase_next;
      acc   <= acc_next;
      radix <= radix_next;
      neg   <= neg_next;
      seen  <= seen_next;
      ovf   <= ovf_next;
      cnt   <= cnt_next;
    end
  end

  // pending stage: snapshot of a finished string
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_xfer && s_tlast) begin
      pend_valid <= 1'b1;
    end else if (out_load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && s_tlast) begin
      pend_acc   <= acc_next;
      pend_ovf   <= ovf_next;
      pend_seen  <= fin_seen;
      pend_neg   <= neg_next;
      pend_sm    <= signed_mode;
      pend_cnt   <= fin_cnt;
      pend_radix <= fin_radix;
    end
  end

  // sign and range check
  logic                        chk_err;
  logic [rtp_pkg::VALUE_W-1:0] chk_val;

  always_comb begin
    chk_err = !pend_seen || pend_ovf;
    chk_val = pend_acc;
    if (!chk_err && pend_sm) begin
      if (pend_neg) begin
        // magnitude up to 2^63 fits
        if (pend_acc[rtp_pkg::VALUE_W-1] && pend_acc[rtp_pkg::VALUE_W-2:0] != '0) begin
          chk_err = 1'b1;
        end else begin
          chk_val = '0 - pend_acc;
        end
      end else if (pend_acc[rtp_pkg::VALUE_W-1]) begin
        chk_err = 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= chk_err ? '0 : chk_val;
      out_err   <= chk_err;
      out_cnt   <= chk_err ? '0 : pend_cnt;
      out_radix <= pend_radix;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_radix, out_cnt, out_err, out_value};

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && out_valid && !m_tready) |-> !s_tready)
    else $error("input taken while the pending stage is blocked");

  a_last_fills_pending: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> (pend_valid && phase == rtp_pkg::PH_START))
    else $error("last byte did not close the string");

  a_acc_needs_digit: assert property (@(posedge clk) disable iff (rst)
    (acc != '0) |-> seen)
    else $error("accumulator nonzero without a digit");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err) |-> (out_value == '0 && out_cnt == '0))
    else $error("error result carries data");

  a_ovf_stops: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (phase == rtp_pkg::PH_STOPPED))
    else $error("parsing continued after overflow");

endmodule

[verif/radix_integer_text_parser_top_test.sv]
// Testbench: radix integer text parser, directed table plus random strings checked by a predictor.
`timescale 1ns / 1ps

module radix_integer_text_parser_top_test;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;  // char_byte[7:0]
  logic        s_tuser   = 1'b0;   // char_valid
  logic        s_tlast   = 1'b0;   // last_char
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [87:0] m_tdata;            // value_bits[63:0], parse_error, consumed_count, radix_used
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [rtp_pkg::RADIX_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  radix_integer_text_parser_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam int unsigned NOT_A_DIGIT = 255;
  localparam int unsigned ITEM_GOAL   = 450;  // input transfers over the whole run

  // one parsed number as it leaves the block
  typedef struct packed {
    logic [rtp_pkg::RADIX_W-1:0] radix;
    logic [rtp_pkg::COUNT_W-1:0] consumed;
    logic                        bad;
    logic [63:0]                 number;
  } result_t;

  // one input transfer
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       ends;
  } text_item_t;

  // directed row: config, up to four characters (first char in the highest used byte),
  // an empty transfer after the first char (gap), an empty closing transfer (tail_empty),
  // and a typed expectation where one is obvious
  typedef struct packed {
    logic [5:0]  radix;
    logic        sgn;
    logic [31:0] text;
    logic [2:0]  len;
    logic        gap;
    logic        tail_empty;
    logic        typed;
    logic [63:0] val;
    logic        err;
    logic [15:0] cnt;
    logic [5:0]  rdx;
  } dir_row_t;

  localparam dir_row_t DIRECTED [13] = '{
    // radix sgn text         len  gap  tail typed value     err  cnt    radix
    '{6'd0,  1'b0, 32'h0,        3'd0, 1'b0, 1'b1, 1'b1, 64'd0,   1'b1, 16'd0, rtp_pkg::RADIX_10},
    '{6'd0,  1'b0, "0",          3'd1, 1'b0, 1'b0, 1'b1, 64'd0,   1'b0, 16'd1, rtp_pkg::RADIX_10},
    '{6'd0,  1'b0, "0x1f",       3'd4, 1'b0, 1'b0, 1'b1, 64'd31,  1'b0, 16'd4, rtp_pkg::RADIX_16},
    '{6'd0,  1'b0, "0x",         3'd2, 1'b0, 1'b0, 1'b1, 64'd0,   1'b1, 16'd0, rtp_pkg::RADIX_16},
    '{6'd0,  1'b0, "017",        3'd3, 1'b0, 1'b0, 1'b0, 64'd0,   1'b0, 16'd0, 6'd0},
    '{6'd0,  1'b0, "0z",         3'd2, 1'b0, 1'b0, 1'b1, 64'd0,   1'b0, 16'd1, rtp_pkg::RADIX_10},
    '{6'd0,  1'b0, "-5",         3'd2, 1'b0, 1'b0, 1'b1, 64'd0,   1'b1, 16'd0, rtp_pkg::RADIX_10},
    '{6'd0,  1'b1, "-5",         3'd2, 1'b0, 1'b0, 1'b1, -64'sd5, 1'b0, 16'd2, rtp_pkg::RADIX_10},
    '{6'd0,  1'b1, "-",          3'd1, 1'b0, 1'b0, 1'b1, 64'd0,   1'b1, 16'd0, rtp_pkg::RADIX_10},
    '{6'd36, 1'b0, "Zz",         3'd2, 1'b0, 1'b0, 1'b1, 64'd1295, 1'b0, 16'd2, 6'd36},
    '{6'd1,  1'b0, {"0", 8'h00}, 3'd2, 1'b0, 1'b0, 1'b1, 64'd0,   1'b0, 16'd1, 6'd1},
    '{6'd63, 1'b0, "zZ",         3'd2, 1'b0, 1'b0, 1'b0, 64'd0,   1'b0, 16'd0, 6'd0},
    '{6'd10, 1'b0, {"7", 8'hFF}, 3'd2, 1'b1, 1'b1, 1'b1, 64'd7,   1'b0, 16'd1, rtp_pkg::RADIX_10}
  };

  // digit-decode neighbors and prefix letters for noise
  localparam logic [7:0] TRICKY [17] = '{
    rtp_pkg::CH_0, rtp_pkg::CH_9, rtp_pkg::CH_LX, rtp_pkg::CH_UX, rtp_pkg::CH_LB,
    rtp_pkg::CH_UB, rtp_pkg::CH_LO, rtp_pkg::CH_MINUS, rtp_pkg::CH_LA, rtp_pkg::CH_LZ,
    rtp_pkg::CH_UA, rtp_pkg::CH_UZ,
    8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h7B
  };

  localparam logic [5:0] EARLY_RADIX [5] = '{6'd0, 6'd63, 6'd1, 6'd36, 6'd0};

  // ---------------------------------------------------------------------------
  // Predictor state: parse state and our copy of the two registers
  // ---------------------------------------------------------------------------
  logic [2:0]  pr_phase  = rtp_pkg::PH_START;
  logic [63:0] pr_acc    = '0;
  logic [5:0]  pr_radix  = '0;
  logic        pr_neg    = 1'b0;
  logic        pr_digit  = 1'b0;
  logic        pr_ovf    = 1'b0;
  logic [15:0] pr_count  = '0;
  logic [5:0]  cf_radix  = '0;
  logic        cf_signed = 1'b0;

  result_t     parsed_numbers[$];   // numbers the block still owes us
  text_item_t  spelled[$];          // string under construction

  int unsigned send_gap_pct = 8;
  int unsigned recv_gap_pct = 59;
  int unsigned hold_request = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned error_results = 0;
  int unsigned chars_sent = 0;
  int unsigned items_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned settings_used = 0;

  function automatic void clear_number();
    pr_phase = rtp_pkg::PH_START;
    pr_acc   = '0;
    pr_radix = '0;
    pr_neg   = 1'b0;
    pr_digit = 1'b0;
    pr_ovf   = 1'b0;
    pr_count = '0;
  endfunction

  function automatic void bump_count(input int unsigned n);
    int unsigned s;
    s = pr_count + n;
    pr_count = (s > rtp_pkg::MAX_COUNT) ? rtp_pkg::MAX_COUNT : 16'(s);
  endfunction

  // fold one character into the accumulator; a non-digit or overflow stops the parse
  function automatic void fold_digit(input logic [7:0] c);
    int unsigned d;
    logic [63:0] r;
    r = {58'd0, pr_radix};
    if (c >= rtp_pkg::CH_0 && c <= rtp_pkg::CH_9) d = c - rtp_pkg::CH_0;
    else if (c >= rtp_pkg::CH_LA && c <= rtp_pkg::CH_LZ) d = c - rtp_pkg::CH_LA + 10;
    else if (c >= rtp_pkg::CH_UA && c <= rtp_pkg::CH_UZ) d = c - rtp_pkg::CH_UA + 10;
    else d = NOT_A_DIGIT;
    if (d == NOT_A_DIGIT || r == 0 || 64'(d) >= r) begin
      pr_phase = rtp_pkg::PH_STOPPED;
      return;
    end
    if (pr_acc > (ALL_ONES - 64'(d)) / r) begin
      pr_ovf   = 1'b1;
      pr_phase = rtp_pkg::PH_STOPPED;
      return;
    end
    pr_acc   = pr_acc * r + 64'(d);
    pr_digit = 1'b1;
    bump_count(1);
  endfunction

  function automatic void start_digits(input logic [7:0] c);
    if (cf_radix == 0) begin
      if (c == rtp_pkg::CH_0) begin
        pr_phase = rtp_pkg::PH_ZERO;
        return;
      end
      pr_radix = rtp_pkg::RADIX_10;
    end else begin
      pr_radix = cf_radix;
    end
    pr_phase = rtp_pkg::PH_DIGITS;
    fold_digit(c);
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    case (pr_phase)
      rtp_pkg::PH_START: begin
        if (cf_signed && c == rtp_pkg::CH_MINUS) begin
          pr_neg = 1'b1;
          bump_count(1);
          pr_phase = rtp_pkg::PH_NUMSTART;
        end else begin
          start_digits(c);
        end
      end
      rtp_pkg::PH_NUMSTART: start_digits(c);
      rtp_pkg::PH_ZERO: begin
        // second char after a leading zero picks the radix
        pr_phase = rtp_pkg::PH_DIGITS;
        if (c == rtp_pkg::CH_LX || c == rtp_pkg::CH_UX) begin
          pr_radix = rtp_pkg::RADIX_16;
          bump_count(2);
        end else if (c == rtp_pkg::CH_LB || c == rtp_pkg::CH_UB) begin
          pr_radix = rtp_pkg::RADIX_2;
          bump_count(2);
        end else if (c == rtp_pkg::CH_LO) begin
          pr_radix = rtp_pkg::RADIX_8;
          bump_count(2);
        end else if (c >= rtp_pkg::CH_0 && c <= rtp_pkg::CH_9) begin
          pr_radix = rtp_pkg::RADIX_8;
          bump_count(1);
          fold_digit(c);
        end else begin
          pr_radix = rtp_pkg::RADIX_10;
          fold_digit(rtp_pkg::CH_0);
          fold_digit(c);
        end
      end
      rtp_pkg::PH_DIGITS: fold_digit(c);
      default: ;
    endcase
  endfunction

  // close the string: radix fixup, sign and range check, then back to the start
  function automatic result_t finish_number();
    result_t res;
    logic err;
    logic [63:0] v;
    if (pr_phase == rtp_pkg::PH_START || pr_phase == rtp_pkg::PH_NUMSTART) begin
      pr_radix = (cf_radix != 0) ? cf_radix : rtp_pkg::RADIX_10;
    end else if (pr_phase == rtp_pkg::PH_ZERO) begin
      pr_radix = rtp_pkg::RADIX_10;
      fold_digit(rtp_pkg::CH_0);
    end
    err = !pr_digit || pr_ovf;
    v = pr_acc;
    if (!err && cf_signed) begin
      if (pr_neg) begin
        if (pr_acc > SIGN_BIT) err = 1'b1;
        else v = 64'd0 - pr_acc;
      end else if (pr_acc > INT_MAX) begin
        err = 1'b1;
      end
    end
    res.number   = err ? 64'd0 : v;
    res.bad      = err;
    res.consumed = err ? 16'd0 : pr_count;
    res.radix    = pr_radix;
    clear_number();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input logic [87:0] word);
    result_t want;
    logic [63:0] g_num;
    logic        g_bad;
    logic [15:0] g_cnt;
    logic [5:0]  g_rdx;
    g_num = word[63:0];
    g_bad = word[64];
    g_cnt = word[80:65];
    g_rdx = word[86:81];
    results_seen++;
    if (g_bad) error_results++;
    if (parsed_numbers.size() == 0) begin
      note_mismatch("result with nothing pending", g_num, 64'd0);
      return;
    end
    want = parsed_numbers.pop_front();
    if (g_num !== want.number)   note_mismatch("value_bits", g_num, want.number);
    if (g_bad !== want.bad)      note_mismatch("parse_error", 64'(g_bad), 64'(want.bad));
    if (g_cnt !== want.consumed) note_mismatch("consumed_count", 64'(g_cnt), 64'(want.consumed));
    if (g_rdx !== want.radix)    note_mismatch("radix_used", 64'(g_rdx), 64'(want.radix));
  endtask

  // outputs sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
  end

  // Result side: random ready, or a long hold-off when asked for.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Tasks are entered and left just after a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic v, input logic l,
                           input logic typed, input result_t row_expect);
    result_t r;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      // idle cycle, junk on the data lines
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
      s_tlast  <= 1'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= v;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // transfer taken at this edge
    items_sent++;
    if (v) begin
      parse_char(c);
      chars_sent++;
    end
    if (l) begin
      r = finish_number();
      parsed_numbers.push_back(typed ? row_expect : r);
      strings_sent++;
    end
    @(negedge clk);
  endtask

  // stop offering input, wait for every owed result, then let the pipe empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (parsed_numbers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input logic [5:0] radix, input logic sgn);
    cfg_we    <= 1'b1;
    cfg_index <= rtp_pkg::CFG_RADIX;
    cfg_data  <= radix;
    @(negedge clk);
    cfg_index <= rtp_pkg::CFG_SIGNED;
    cfg_data  <= {5'($urandom), sgn};  // upper bits are don't-care
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= 6'($urandom);
    @(negedge clk);
    cf_radix  = radix;
    cf_signed = sgn;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // String builders for the random part
  // ---------------------------------------------------------------------------
  function automatic void put_char(input logic [7:0] c);
    text_item_t it;
    if ($urandom_range(0, 11) == 0) begin
      // stray empty transfer inside the string
      it.ch = 8'($urandom);
      it.has_char = 1'b0;
      it.ends = 1'b0;
      spelled.push_back(it);
    end
    it.ch = c;
    it.has_char = 1'b1;
    it.ends = 1'b0;
    spelled.push_back(it);
  endfunction

  function automatic logic [7:0] digit_glyph(input int unsigned d);
    if (d < 10) return rtp_pkg::CH_0 + 8'(d);
    return ($urandom_range(0, 1) ? rtp_pkg::CH_UA : rtp_pkg::CH_LA) + 8'(d - 10);
  endfunction

  function automatic void spell_value(input logic [63:0] v, input int unsigned r);
    logic [7:0] glyphs[$];
    int unsigned n;
    if (r < 2) begin
      // radix 0/1: runs of zeros, sometimes a one that radix 1 rejects
      n = $urandom_range(1, 5);
      repeat (n) put_char(rtp_pkg::CH_0);
      if ($urandom_range(0, 3) == 0) put_char("1");
      return;
    end
    if (r > 36) begin
      n = $urandom_range(1, 13);
      repeat (n) put_char(digit_glyph($urandom_range(0, 35)));
      return;
    end
    do begin
      glyphs.push_front(digit_glyph(32'(v % 64'(r))));
      v = v / 64'(r);
    end while (v != 0);
    foreach (glyphs[i]) put_char(glyphs[i]);
  endfunction

  // well-formed number: optional sign, prefix in auto mode, digits, maybe junk after
  function automatic void spell_number();
    int unsigned r;
    logic [63:0] v;
    logic done;
    done = 1'b0;
    if (cf_signed ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) == 0))
      put_char(rtp_pkg::CH_MINUS);
    r = cf_radix;
    if (cf_radix == 0) begin
      case ($urandom_range(0, 6))
        0: begin
          put_char(rtp_pkg::CH_0);
          put_char($urandom_range(0, 1) ? rtp_pkg::CH_LX : rtp_pkg::CH_UX);
          r = 16;
        end
        1: begin
          put_char(rtp_pkg::CH_0);
          put_char($urandom_range(0, 1) ? rtp_pkg::CH_LB : rtp_pkg::CH_UB);
          r = 2;
        end
        2: begin put_char(rtp_pkg::CH_0); put_char(rtp_pkg::CH_LO); r = 8; end
        3: begin put_char(rtp_pkg::CH_0); r = 8; end
        default: r = 10;
      endcase
    end
    case ($urandom_range(0, 9))
      0: v = 64'd0;
      1: v = ALL_ONES;
      2: v = INT_MAX;
      3: v = SIGN_BIT;
      4: v = SIGN_BIT + 64'd1;
      5: v = 64'($urandom_range(0, 999));
      6: begin
        // last digit lands just at or just past 2^64-1
        if (r >= 2 && r <= 36) begin
          spell_value(ALL_ONES / 64'(r), r);
          put_char(digit_glyph(32'(ALL_ONES % 64'(r)) + $urandom_range(0, 1)));
          done = 1'b1;
        end
        v = 64'd7;
      end
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    if (!done) spell_value(v, r);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3))
        put_char($urandom_range(0, 1) ? TRICKY[$urandom_range(0, 16)] : 8'($urandom));
    end
  endfunction

  function automatic void spell_noise();
    text_item_t it;
    repeat ($urandom_range(0, 6)) begin
      it.ch = $urandom_range(0, 1) ? TRICKY[$urandom_range(0, 16)] : 8'($urandom);
      it.has_char = ($urandom_range(0, 4) != 0);
      it.ends = 1'b0;
      spelled.push_back(it);
    end
  endfunction

  // prefixes and signs that lead nowhere
  function automatic void spell_broken();
    case ($urandom_range(0, 5))
      0: begin put_char(rtp_pkg::CH_0); put_char(rtp_pkg::CH_UX); end
      1: begin put_char(rtp_pkg::CH_0); put_char(rtp_pkg::CH_LB); put_char("2"); end
      2: put_char(rtp_pkg::CH_MINUS);
      3: begin put_char(rtp_pkg::CH_MINUS); put_char(rtp_pkg::CH_MINUS); put_char("1"); end
      4: begin put_char(rtp_pkg::CH_0); put_char("O"); put_char("7"); end  // uppercase O: no prefix
      default: begin put_char(rtp_pkg::CH_0); put_char(rtp_pkg::CH_LO); put_char("8"); end
    endcase
  endfunction

  function automatic void close_string();
    text_item_t it;
    if (spelled.size() == 0 || $urandom_range(0, 3) == 0) begin
      it.ch = 8'($urandom);
      it.has_char = 1'b0;
      it.ends = 1'b1;
      spelled.push_back(it);
    end else begin
      it = spelled.pop_back();
      it.ends = 1'b1;
      spelled.push_back(it);
    end
  endfunction

  task automatic send_spelled();
    result_t none;
    none = '0;
    foreach (spelled[i])
      send_char(spelled[i].ch, spelled[i].has_char, spelled[i].ends, 1'b0, none);
    spelled.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    row;
    result_t     row_expect;
    result_t     none;
    int          len;
    int          rand_start;
    int          span;
    int          done_items;
    int unsigned phase_no;
    int unsigned pick;
    logic [5:0]  radix;
    none = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table; the first rows run on the reset register values.
    foreach (DIRECTED[k]) begin
      row = DIRECTED[k];
      if (row.radix != cf_radix || row.sgn != cf_signed) begin
        settle();
        write_regs(row.radix, row.sgn);
      end
      row_expect.number   = row.val;
      row_expect.bad      = row.err;
      row_expect.consumed = row.cnt;
      row_expect.radix    = row.rdx;
      len = row.len;
      for (int i = 0; i < len; i++) begin
        send_char(row.text[8*(len-1-i) +: 8], 1'b1, !row.tail_empty && i == len - 1,
                  row.typed, row_expect);
        if (i == 0 && row.gap) send_char(8'($urandom), 1'b0, 1'b0, 1'b0, none);
      end
      if (row.tail_empty) send_char(8'($urandom), 1'b0, 1'b1, row.typed, row_expect);
    end

    // Back-pressure: the result side stalls for a long stretch while one-char
    // strings keep coming, so both internal stages fill and s_tready drops.
    settle();
    write_regs(6'd0, 1'b1);
    send_gap_pct = 0;
    hold_request = 80;
    repeat (20) begin
      put_char(digit_glyph($urandom_range(0, 9)));
      close_string();
      send_spelled();
    end
    settle();

    // Random part, a register setting per phase; idle pattern follows progress
    // through the remaining transfer budget.
    rand_start = int'(items_sent);
    span = int'(ITEM_GOAL) - rand_start;
    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      if (phase_no < 5) begin
        radix = EARLY_RADIX[phase_no];
      end else begin
        pick = $urandom_range(0, 9);
        case (pick) inside
          0, 1, 2: radix = 6'd0;
          3: radix = rtp_pkg::RADIX_2;
          4: radix = rtp_pkg::RADIX_8;
          5: radix = rtp_pkg::RADIX_10;
          6: radix = rtp_pkg::RADIX_16;
          7: radix = 6'd36;
          8: radix = 6'd37;
          default: radix = 6'($urandom_range(0, 63));
        endcase
      end
      write_regs(radix, (phase_no < 5) ? phase_no[0] : 1'($urandom));
      for (int n = 0; n < 6 && items_sent < ITEM_GOAL; n++) begin
        done_items = int'(items_sent) - rand_start;
        if (3 * done_items < span) begin
          send_gap_pct = 8;
          recv_gap_pct = 59;
        end else if (3 * done_items < 2 * span) begin
          send_gap_pct = 59;
          recv_gap_pct = 8;
        end else begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
        pick = $urandom_range(0, 19);
        if (pick < 13) spell_number();
        else if (pick < 17) spell_noise();
        else spell_broken();
        close_string();
        send_spelled();
      end
      settle();
      phase_no++;
    end

    // drain, then wait quietly to catch anything extra
    s_tvalid <= 1'b0;
    while (parsed_numbers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d strings, %0d transfers (%0d characters), %0d results, %0d errors",
             strings_sent, items_sent, chars_sent, results_seen, error_results);
    $display("register settings %0d, incl. auto/fixed radix 1..63, signed mode and stalls",
             settings_used);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #6_000_000;
    $display("timeout: %0d results still owed", parsed_numbers.size());
    $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
rtl/rtp_pkg.sv
rtl/radix_integer_text_parser_top.sv
verif/radix_integer_text_parser_top_test.sv
